// File: rtl/core/i2cbs_pkg.sv
// Shared types, codes and the control program of the I2C master bit sequencer.
package i2cbs_pkg;

  localparam int BYTE_BITS = 8;
  localparam int HOLD_W    = 16;
  localparam int STEP_W    = 5;
  localparam int BIT_CNT_W = $clog2(BYTE_BITS);

  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

  // Command codes on req_type.
  typedef enum logic [2:0] {
    REQ_START      = 3'd0,
    REQ_RESTART    = 3'd1,
    REQ_STOP       = 3'd2,
    REQ_WRITE_BYTE = 3'd3,
    REQ_READ_BYTE  = 3'd4,
    REQ_WRITE_ADDR = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_START_BSY = 2'd1,
    ST_BUS_IDLE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SCL_KEEP = 2'd0,
    SCL_LOW  = 2'd1,
    SCL_HIGH = 2'd2
  } scl_sel_t;

  typedef enum logic [1:0] {
    SDA_LOW  = 2'd0,
    SDA_HIGH = 2'd1,
    SDA_BIT  = 2'd2,
    SDA_ACK  = 2'd3
  } sda_sel_t;

  // One control word per program step.
  typedef struct packed {
    scl_sel_t scl_sel;
    sda_sel_t sda_sel;
    logic     sample;
    logic     last;
    logic     shift;
    logic     loop;
    logic     take_ack;
    logic     rx_out;
    logic     err;
    step_t    target;
  } ctrl_t;

  // Entry points of the program.
  localparam step_t STEP_START = step_t'(0);
  localparam step_t STEP_STOP  = step_t'(4);
  localparam step_t STEP_WRITE = step_t'(7);
  localparam step_t STEP_WLOOP = step_t'(9);
  localparam step_t STEP_READ  = step_t'(13);
  localparam step_t STEP_RBIT  = step_t'(14);
  localparam step_t STEP_ERROR = step_t'(19);

  function automatic ctrl_t cw(input scl_sel_t s, input sda_sel_t d, input logic sample,
                               input logic last, input logic shift, input logic loop,
                               input logic take_ack, input logic rx_out, input logic err,
                               input step_t target);
    ctrl_t c;
    c.scl_sel  = s;
    c.sda_sel  = d;
    c.sample   = sample;
    c.last     = last;
    c.shift    = shift;
    c.loop     = loop;
    c.take_ack = take_ack;
    c.rx_out   = rx_out;
    c.err      = err;
    c.target   = target;
    return c;
  endfunction

  // The control program. Flags: sample, last, shift, loop, take_ack, rx_out, err.
  function automatic ctrl_t prog_rom(input step_t step);
    ctrl_t c;
    unique case (step)
      // Start or repeated start.
      step_t'(0):  c = cw(SCL_KEEP, SDA_HIGH, 0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(1):  c = cw(SCL_HIGH, SDA_HIGH, 0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(2):  c = cw(SCL_HIGH, SDA_LOW,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(3):  c = cw(SCL_LOW,  SDA_LOW,  0, 1, 0, 0, 0, 0, 0, STEP_START);
      // Stop.
      step_t'(4):  c = cw(SCL_KEEP, SDA_LOW,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(5):  c = cw(SCL_HIGH, SDA_LOW,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(6):  c = cw(SCL_HIGH, SDA_HIGH, 0, 1, 0, 0, 0, 0, 0, STEP_START);
      // Write: eight data bits, then the acknowledge slot.
      step_t'(7):  c = cw(SCL_KEEP, SDA_BIT,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(8):  c = cw(SCL_HIGH, SDA_BIT,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(9):  c = cw(SCL_LOW,  SDA_BIT,  0, 0, 1, 1, 0, 0, 0, STEP_WRITE);
      step_t'(10): c = cw(SCL_KEEP, SDA_HIGH, 0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(11): c = cw(SCL_HIGH, SDA_HIGH, 1, 0, 0, 0, 1, 0, 0, STEP_START);
      step_t'(12): c = cw(SCL_LOW,  SDA_HIGH, 0, 1, 0, 0, 0, 0, 0, STEP_START);
      // Read: release SDA, eight samples, then drive the acknowledge.
      step_t'(13): c = cw(SCL_KEEP, SDA_HIGH, 0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(14): c = cw(SCL_HIGH, SDA_HIGH, 1, 0, 1, 0, 0, 0, 0, STEP_START);
      step_t'(15): c = cw(SCL_LOW,  SDA_HIGH, 0, 0, 0, 1, 0, 0, 0, STEP_RBIT);
      step_t'(16): c = cw(SCL_KEEP, SDA_ACK,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(17): c = cw(SCL_HIGH, SDA_ACK,  0, 0, 0, 0, 0, 0, 0, STEP_START);
      step_t'(18): c = cw(SCL_LOW,  SDA_ACK,  0, 1, 0, 0, 0, 1, 0, STEP_START);
      // Refused command: a single result with the lines unchanged.
      step_t'(19): c = cw(SCL_KEEP, SDA_HIGH, 0, 1, 0, 0, 0, 0, 1, STEP_START);
      default:     c = cw(SCL_KEEP, SDA_HIGH, 0, 1, 0, 0, 0, 0, 1, STEP_START);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/i2cbs_microseq.sv
// Step counter, bit loop counter and control store of the bit sequencer.
module i2cbs_microseq
  import i2cbs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  step_t entry,
  input  logic  advance,
  output ctrl_t ctrl
);

  step_t    step;
  bit_cnt_t bit_cnt;

  assign ctrl = prog_rom(step);

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= STEP_START;
      bit_cnt <= '0;
    end else if (load) begin
      step    <= entry;
      bit_cnt <= bit_cnt_t'(BYTE_BITS - 1);
    end else if (advance) begin
      // A loop step jumps back until every bit of the byte has been handled.
      if (ctrl.loop && (bit_cnt != '0)) begin
        step    <= ctrl.target;
        bit_cnt <= bit_cnt - bit_cnt_t'(1);
      end else begin
        step <= step + step_t'(1);
      end
    end
  end

endmodule

// File: rtl/core/i2c_master_bit_sequencer.sv
// I2C master bit sequencer: turns bus commands into ordered SCL/SDA line phases.
//
// Input channel (in_valid/in_ready): one bus command per transfer, with the
// target's sampled levels (slave_data, slave_ack) supplied alongside it.
// Output channel (out_valid/out_ready): one transfer per line phase, the final
// one of a command flagged by last. Configuration channel (cfg_valid/cfg_ready)
// writes phase_hold, the number of extra cycles spent before each phase.
// One command is handled at a time; in_ready is high only while idle.
// In each phase the hold counter first runs down from phase_hold; then the
// control word is applied and the result registered, and then the output
// transfer follows once out_ready is high. A write has 27 line phases, a read
// 20, a start 4 and a stop 3.
// A refused command gives one result. Command codes six and seven are dropped.
// The pace is set by the control program stepping one phase at a time.
// If out_ready is low the result register holds and the sequencer waits.
// Reset releases both lines, clears the busy flag, the last acknowledge and
// phase_hold, and returns the block to idle.
module i2c_master_bit_sequencer
  import i2cbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic [6:0]        target_address,
  input  logic              direction,
  input  logic              ack_level,
  input  logic [7:0]        slave_data,
  input  logic              slave_ack,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              scl_level,
  output logic              sda_level,
  output logic              sample_point,
  output logic              last,
  output logic [1:0]        status,
  output logic [7:0]        rx_byte,
  output logic              ack_seen,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HOLD_W-1:0] phase_hold
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HOLD = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [HOLD_W-1:0] hold_reg;
  logic [HOLD_W-1:0] hold_cnt;
  logic              bus_busy;
  logic              last_ack;
  logic              scl_drive;
  logic              sda_drive;

  logic [7:0] shreg;
  logic [7:0] rx_acc;
  logic       ack_level_r;
  logic       slave_ack_r;
  status_t    err_status;

  logic    accept;
  logic    req_ok;
  logic    refuse_busy;
  logic    refuse_idle;
  logic    exec;
  logic    advance;
  step_t   entry;
  ctrl_t   ctrl;
  logic    scl_new;
  logic    sda_new;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign cfg_ready = 1'b1;

  assign req_ok      = (req_type <= 3'(REQ_WRITE_ADDR));
  assign accept      = in_valid && in_ready && req_ok;
  assign refuse_busy = (req_type == 3'(REQ_START)) && bus_busy;
  assign refuse_idle = (req_type != 3'(REQ_START)) && !bus_busy;
  assign exec        = (state == S_HOLD) && (hold_cnt == '0);
  assign advance     = (state == S_EMIT) && out_ready && !last;

  always_comb begin
    if (refuse_busy || refuse_idle) begin
      entry = STEP_ERROR;
    end else begin
      unique case (req_type)
        3'(REQ_START), 3'(REQ_RESTART):       entry = STEP_START;
        3'(REQ_STOP):                         entry = STEP_STOP;
        3'(REQ_WRITE_BYTE), 3'(REQ_WRITE_ADDR): entry = STEP_WRITE;
        3'(REQ_READ_BYTE):                    entry = STEP_READ;
        default:                              entry = STEP_ERROR;
      endcase
    end
  end

  i2cbs_microseq u_seq (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .entry   (entry),
    .advance (advance),
    .ctrl    (ctrl)
  );

  // Line levels selected by the current control word; refusals keep the lines.
  always_comb begin
    unique case (ctrl.scl_sel)
      SCL_LOW:  scl_new = 1'b0;
      SCL_HIGH: scl_new = 1'b1;
      default:  scl_new = scl_drive;
    endcase
    unique case (ctrl.sda_sel)
      SDA_LOW:  sda_new = 1'b0;
      SDA_HIGH: sda_new = 1'b1;
      SDA_BIT:  sda_new = shreg[7];
      SDA_ACK:  sda_new = ack_level_r;
      default:  sda_new = sda_drive;
    endcase
    if (ctrl.err) begin
      scl_new = scl_drive;
      sda_new = sda_drive;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_HOLD;
      S_HOLD: if (exec) state_next = S_EMIT;
      S_EMIT: begin
        if (out_ready) state_next = last ? S_IDLE : S_HOLD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hold_reg  <= '0;
      hold_cnt  <= '0;
      bus_busy  <= 1'b0;
      last_ack  <= 1'b0;
      scl_drive <= 1'b1;
      sda_drive <= 1'b1;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        hold_reg <= phase_hold;
      end
      if (accept || advance) begin
        hold_cnt <= hold_reg;
      end else if ((state == S_HOLD) && (hold_cnt != '0)) begin
        hold_cnt <= hold_cnt - HOLD_W'(1);
      end
      if (accept && !refuse_busy && !refuse_idle) begin
        if (req_type == 3'(REQ_START)) begin
          bus_busy <= 1'b1;
        end else if (req_type == 3'(REQ_STOP)) begin
          bus_busy <= 1'b0;
        end
      end
      if (exec) begin
        scl_drive <= scl_new;
        sda_drive <= sda_new;
        if (ctrl.take_ack) begin
          last_ack <= slave_ack_r;
        end
      end
    end
  end

  // Command operands and the result register.
  always_ff @(posedge clk) begin
    if (accept) begin
      ack_level_r <= ack_level;
      slave_ack_r <= slave_ack;
      rx_acc      <= '0;
      err_status  <= refuse_busy ? ST_START_BSY : ST_BUS_IDLE;
      if (req_type == 3'(REQ_WRITE_ADDR)) begin
        shreg <= {target_address, direction};
      end else if (req_type == 3'(REQ_READ_BYTE)) begin
        shreg <= slave_data;
      end else begin
        shreg <= tx_byte;
      end
    end else if (exec && ctrl.shift) begin
      // Bits leave MSB first; on a read the sampled bit enters the accumulator.
      shreg  <= {shreg[6:0], 1'b0};
      rx_acc <= {rx_acc[6:0], shreg[7]};
    end
    if (exec) begin
      scl_level    <= scl_new;
      sda_level    <= sda_new;
      sample_point <= ctrl.sample;
      last         <= ctrl.last;
      status       <= ctrl.err ? 2'(err_status) : 2'(ST_OK);
      rx_byte      <= ctrl.rx_out ? rx_acc : 8'd0;
      ack_seen     <= ctrl.take_ack ? slave_ack_r : last_ack;
    end
  end

endmodule

// File: rtl/core/i2cbs_checker.sv
// Port-level checker for the I2C master bit sequencer, bound to the top level.
module i2cbs_checker
  import i2cbs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [2:0] req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       sample_point,
  input logic       last,
  input logic [1:0] status,
  input logic [7:0] rx_byte,
  input logic       ack_seen
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({scl_level, sda_level, sample_point, last, status, rx_byte, ack_seen}))
    else $error("result changed while stalled");

  // A refused command is always a single, final result.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != 2'(ST_OK)) |-> last)
    else $error("refusal not flagged as last");

  // The master only samples SDA while SCL is released.
  a_sample_scl: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_point |-> scl_level)
    else $error("sample taken with SCL low");

  // A read byte only appears on the final phase of a command.
  a_rx_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rx_byte != 8'd0) |-> last)
    else $error("read byte before last phase");

  // A command that is taken keeps further commands out.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (req_type <= 3'(REQ_WRITE_ADDR)) |=> !in_ready)
    else $error("new command accepted during a sequence");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .req_type     (req_type),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .scl_level    (scl_level),
  .sda_level    (sda_level),
  .sample_point (sample_point),
  .last         (last),
  .status       (status),
  .rx_byte      (rx_byte),
  .ack_seen     (ack_seen)
);

// File: verif/i2c_seq_checker.sv
// Checker for the I2C master bit sequencer: predicts every line phase and compares it.
module i2c_seq_checker
  import i2cbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [7:0]        tx_byte,
  input  logic [6:0]        target_address,
  input  logic              direction,
  input  logic              ack_level,
  input  logic [7:0]        slave_data,
  input  logic              slave_ack,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              scl_level,
  input  logic              sda_level,
  input  logic              sample_point,
  input  logic              last,
  input  logic [1:0]        status,
  input  logic [7:0]        rx_byte,
  input  logic              ack_seen,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [HOLD_W-1:0] phase_hold,
  output int                fails,
  output int                pending,
  output int                phases_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       scl;
    logic       sda;
    logic       smp;
    logic       fin;
    status_t    st;
    logic [7:0] rx;
    logic       ack;
  } line_phase_t;

  logic              bus_busy;
  logic              ack_last;
  logic              scl_q;
  logic              sda_q;
  logic [HOLD_W-1:0] hold_cfg;
  line_phase_t       phase_q[$];

  task automatic emit(input logic scl, input logic sda, input logic smp, input logic fin,
                      input logic [7:0] rx);
    line_phase_t p;
    scl_q = scl;
    sda_q = sda;
    p.scl = scl;
    p.sda = sda;
    p.smp = smp;
    p.fin = fin;
    p.st  = ST_OK;
    p.rx  = rx;
    p.ack = ack_last;
    phase_q.push_back(p);
  endtask

  // A refused command repeats the present line drive and touches no state.
  task automatic refuse(input status_t why);
    line_phase_t p;
    p.scl = scl_q;
    p.sda = sda_q;
    p.smp = 1'b0;
    p.fin = 1'b1;
    p.st  = why;
    p.rx  = 8'h00;
    p.ack = ack_last;
    phase_q.push_back(p);
  endtask

  task automatic start_cond();
    emit(scl_q, 1'b1, 1'b0, 1'b0, 8'h00);
    emit(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
    emit(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    emit(1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
  endtask

  task automatic shift_out(input logic [7:0] b, input logic sack);
    int j;
    for (j = 7; j >= 0; j--) begin
      emit(scl_q, b[j], 1'b0, 1'b0, 8'h00);
      emit(1'b1, b[j], 1'b0, 1'b0, 8'h00);
      emit(1'b0, b[j], 1'b0, 1'b0, 8'h00);
    end
    emit(scl_q, 1'b1, 1'b0, 1'b0, 8'h00);
    // The acknowledge is taken before the sampling phase is reported.
    ack_last = sack;
    emit(1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
    emit(1'b0, 1'b1, 1'b0, 1'b1, 8'h00);
  endtask

  task automatic shift_in(input logic [7:0] sdat, input logic ackl);
    emit(scl_q, 1'b1, 1'b0, 1'b0, 8'h00);
    repeat (8) begin
      emit(1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
      emit(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    end
    emit(scl_q, ackl, 1'b0, 1'b0, 8'h00);
    emit(1'b1, ackl, 1'b0, 1'b0, 8'h00);
    emit(1'b0, ackl, 1'b0, 1'b1, sdat);
  endtask

  task automatic predict_command();
    case (req_type)
      REQ_START: begin
        if (bus_busy) begin
          refuse(ST_START_BSY);
        end else begin
          bus_busy = 1'b1;
          start_cond();
        end
      end
      REQ_RESTART, REQ_STOP, REQ_WRITE_BYTE, REQ_READ_BYTE, REQ_WRITE_ADDR: begin
        if (!bus_busy) begin
          refuse(ST_BUS_IDLE);
        end else begin
          case (req_type)
            REQ_RESTART: start_cond();
            REQ_STOP: begin
              emit(scl_q, 1'b0, 1'b0, 1'b0, 8'h00);
              emit(1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
              emit(1'b1, 1'b1, 1'b0, 1'b1, 8'h00);
              bus_busy = 1'b0;
            end
            REQ_WRITE_BYTE: shift_out(tx_byte, slave_ack);
            REQ_WRITE_ADDR: shift_out({target_address, direction}, slave_ack);
            default: shift_in(slave_data, ack_level);
          endcase
        end
      end
      default: ;  // undefined codes are dropped without a trace
    endcase
  endtask

  task automatic check_phase();
    line_phase_t e;
    phases_checked++;
    if (phase_q.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("[%0t] line phase with no command waiting: scl=%b sda=%b last=%b st=%0d",
                 $realtime, scl_level, sda_level, last, status);
    end else begin
      e = phase_q.pop_front();
      if (scl_level !== e.scl || sda_level !== e.sda || sample_point !== e.smp ||
          last !== e.fin || status !== e.st || rx_byte !== e.rx || ack_seen !== e.ack) begin
        fails++;
        if (fails <= 10) begin
          $display("[%0t] phase mismatch, exp scl=%b sda=%b smp=%b last=%b st=%0d rx=%h ack=%b",
                   $realtime, e.scl, e.sda, e.smp, e.fin, e.st, e.rx, e.ack);
          $display("[%0t]                 got scl=%b sda=%b smp=%b last=%b st=%0d rx=%h ack=%b",
                   $realtime, scl_level, sda_level, sample_point, last, status, rx_byte,
                   ack_seen);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      bus_busy       = 1'b0;
      ack_last       = 1'b0;
      scl_q          = 1'b1;
      sda_q          = 1'b1;
      hold_cfg       = '0;
      fails          = 0;
      phases_checked = 0;
      phase_q.delete();
    end else begin
      // Results go first so that a transfer in the same cycle meets the right queue.
      if (out_valid && out_ready)
        check_phase();
      if (in_valid && in_ready)
        predict_command();
      if (cfg_valid && cfg_ready)
        hold_cfg = phase_hold;
    end
    pending = phase_q.size();
  end

endmodule

// File: verif/tb.sv
// Testbench top for the I2C master bit sequencer: stimulus, flow control and verdict.
module tb
  import i2cbs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [2:0] REQ_UNDEF_HI = 3'd7;
  localparam int         LONG_STALL   = 400;
  localparam int         CYCLE_LIMIT  = 2000000;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [2:0]        req_type;
  logic [7:0]        tx_byte;
  logic [6:0]        target_address;
  logic              direction;
  logic              ack_level;
  logic [7:0]        slave_data;
  logic              slave_ack;
  logic              out_valid;
  logic              out_ready;
  logic              scl_level;
  logic              sda_level;
  logic              sample_point;
  logic              last;
  logic [1:0]        status;
  logic [7:0]        rx_byte;
  logic              ack_seen;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [HOLD_W-1:0] phase_hold;

  int                fails;
  int                pending;
  int                phases_checked;
  int                n_cmds;
  int                cmd_count[8];
  int                n_settings;
  int                max_hold;
  int                cycles;
  logic [HOLD_W-1:0] hold_now;
  bit                calm;
  bit                long_stall_done;

  i2c_master_bit_sequencer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .tx_byte        (tx_byte),
    .target_address (target_address),
    .direction      (direction),
    .ack_level      (ack_level),
    .slave_data     (slave_data),
    .slave_ack      (slave_ack),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scl_level      (scl_level),
    .sda_level      (sda_level),
    .sample_point   (sample_point),
    .last           (last),
    .status         (status),
    .rx_byte        (rx_byte),
    .ack_seen       (ack_seen),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .phase_hold     (phase_hold)
  );

  i2c_seq_checker chk (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .tx_byte        (tx_byte),
    .target_address (target_address),
    .direction      (direction),
    .ack_level      (ack_level),
    .slave_data     (slave_data),
    .slave_ack      (slave_ack),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scl_level      (scl_level),
    .sda_level      (sda_level),
    .sample_point   (sample_point),
    .last           (last),
    .status         (status),
    .rx_byte        (rx_byte),
    .ack_seen       (ack_seen),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .phase_hold     (phase_hold),
    .fails          (fails),
    .pending        (pending),
    .phases_checked (phases_checked)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Tasks are entered and left at a falling edge.
  task automatic send_cmd(input logic [2:0] rq, input logic [7:0] txb, input logic [6:0] adr,
                          input logic dr, input logic ackl, input logic [7:0] sdat,
                          input logic sack);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= rq;
    tx_byte        <= txb;
    target_address <= adr;
    direction      <= dr;
    ack_level      <= ackl;
    slave_data     <= sdat;
    slave_ack      <= sack;
    do @(posedge clk); while (!in_ready);
    cmd_count[rq]++;
    if (rq <= REQ_WRITE_ADDR)
      n_cmds++;
    @(negedge clk);
  endtask

  task automatic send_rand(input logic [2:0] rq);
    send_cmd(rq, 8'($urandom), 7'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
             1'($urandom));
  endtask

  // Let the bus settle: every phase back, then room for a dropped command to clear.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (int'(hold_now) + 8) @(negedge clk);
  endtask

  task automatic write_hold(input logic [HOLD_W-1:0] v);
    wait_quiet();
    cfg_valid  <= 1'b1;
    phase_hold <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    hold_now = v;
    n_settings++;
    if (int'(v) > max_hold)
      max_hold = int'(v);
  endtask

  // Mostly complete transactions with random content, mixed with stray commands
  // and the odd transaction that never releases the bus.
  task automatic run_traffic(input int n);
    int stop_at;
    stop_at = n_cmds + n;
    while (n_cmds < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_rand(3'($urandom_range(0, 7)));
      end else begin
        send_rand(REQ_START);
        send_rand(REQ_WRITE_ADDR);
        repeat ($urandom_range(0, 4))
          send_rand($urandom_range(0, 1) ? REQ_WRITE_BYTE : REQ_READ_BYTE);
        if ($urandom_range(0, 3) == 0) begin
          send_rand(REQ_RESTART);
          send_rand(REQ_WRITE_ADDR);
          send_rand(REQ_READ_BYTE);
        end
        if ($urandom_range(0, 9) != 0)
          send_rand(REQ_STOP);
      end
    end
  endtask

  // Receiver: short random stalls, quiet stretches, and one long hold-off that
  // leaves the sequencer full with the sender still offering commands.
  initial begin
    int burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_stall_done && n_cmds >= 150) begin
        out_ready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
        long_stall_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 17);
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 30) == 0)
          repeat ($urandom_range(40, 120)) @(negedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d phases outstanding.", pending);
    $display("status: fail");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    req_type       = REQ_START;
    tx_byte        = '0;
    target_address = '0;
    direction      = 1'b0;
    ack_level      = 1'b0;
    slave_data     = '0;
    slave_ack      = 1'b0;
    cfg_valid      = 1'b0;
    phase_hold     = '0;
    hold_now       = '0;
    n_cmds         = 0;
    n_settings     = 0;
    max_hold       = 0;
    calm           = 1'b0;
    long_stall_done = 1'b0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // The longest hold, kept to a single refused command.
    write_hold(16'hFFFF);
    send_rand(REQ_READ_BYTE);

    write_hold(16'h0000);
    send_cmd(REQ_WRITE_BYTE, 8'hFF, 7'h00, 1'b0, 1'b0, 8'h00, 1'b1);
    send_cmd(REQ_RESTART, 8'h00, 7'h7F, 1'b1, 1'b1, 8'hFF, 1'b0);
    send_cmd(REQ_STOP, 8'h5A, 7'h2A, 1'b0, 1'b1, 8'hA5, 1'b1);
    send_cmd(REQ_START, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_START, 8'hFF, 7'h7F, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_WRITE_ADDR, 8'h00, 7'h7F, 1'b1, 1'b0, 8'h00, 1'b1);
    send_cmd(REQ_WRITE_ADDR, 8'hFF, 7'h00, 1'b0, 1'b1, 8'hFF, 1'b0);
    send_cmd(REQ_WRITE_BYTE, 8'hFF, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_WRITE_BYTE, 8'h00, 7'h7F, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_WRITE_BYTE, 8'hA5, 7'h55, 1'b0, 1'b0, 8'h3C, 1'b0);
    send_cmd(REQ_READ_BYTE, 8'h00, 7'h00, 1'b0, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_READ_BYTE, 8'hFF, 7'h7F, 1'b1, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_READ_BYTE, 8'h96, 7'h2A, 1'b0, 1'b0, 8'h5A, 1'b1);
    send_cmd(REQ_UNDEF_LO, 8'hFF, 7'h7F, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_UNDEF_HI, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_RESTART, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_WRITE_ADDR, 8'h00, 7'h55, 1'b1, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_STOP, 8'hFF, 7'h7F, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_READ_BYTE, 8'h00, 7'h00, 1'b0, 1'b0, 8'hC3, 1'b0);
    send_cmd(REQ_UNDEF_HI, 8'hFF, 7'h7F, 1'b1, 1'b1, 8'hFF, 1'b1);
    send_cmd(REQ_START, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    send_cmd(REQ_STOP, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 1'b0);

    write_hold(16'd1);
    run_traffic(80);
    write_hold(16'd0);
    run_traffic(80);
    write_hold(16'd5);
    run_traffic(80);
    write_hold(16'($urandom_range(2, 7)));
    run_traffic(80);
    write_hold(16'd3);
    run_traffic(80);

    // Closing stretch with both sides flowing freely.
    write_hold(16'd0);
    calm = 1'b1;
    run_traffic(50);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (int'(hold_now) + 40) @(negedge clk);

    $display("Sent %0d start, %0d restart, %0d stop, %0d write, %0d read, %0d addr, %0d other.",
             cmd_count[REQ_START], cmd_count[REQ_RESTART], cmd_count[REQ_STOP],
             cmd_count[REQ_WRITE_BYTE], cmd_count[REQ_READ_BYTE], cmd_count[REQ_WRITE_ADDR],
             cmd_count[REQ_UNDEF_LO] + cmd_count[REQ_UNDEF_HI]);
    $display("Checked %0d line phases across %0d hold settings, longest %0d cycles; %0d errors.",
             phases_checked, n_settings, max_hold, fails);
    if (fails == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
